### sv/booth_sign_magnitude_fraction_multiply_defines.svh
`ifndef BOOTH_SIGN_MAGNITUDE_FRACTION_MULTIPLY_DEFINES_SVH
`define BOOTH_SIGN_MAGNITUDE_FRACTION_MULTIPLY_DEFINES_SVH

// Checked only outside reset.
`define BSMF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define BSMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/bsmf_pkg.sv
package bsmf_pkg;

   // Booth recoding of {y[i], y[i-1]}
   localparam logic [1:0] BOOTH_SUB = 2'b10;
   localparam logic [1:0] BOOTH_ADD = 2'b01;

endpackage

### sv/bsmf_cell.sv
module bsmf_cell
   import bsmf_pkg::*;
#(
   parameter int WIDTH = 16,
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [WIDTH+1:0]     in_x,
   input  logic [WIDTH:0]       in_y,
   input  logic [2*WIDTH+1:0]   in_acc,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [WIDTH+1:0]     out_x,
   output logic [WIDTH:0]       out_y,
   output logic [2*WIDTH+1:0]   out_acc
);

   localparam int AW = 2*WIDTH+2;
   localparam int XW = WIDTH+2;

   logic            valid_ff;
   logic [XW-1:0]   x_ff;
   logic [WIDTH:0]  y_ff;
   logic [AW-1:0]   acc_ff;
   logic [AW-1:0]   acc_in;
   logic [AW-1:0]   addend;
   logic [1:0]      pair;

   generate
      if (INDEX == 0) begin : g_first
         assign pair = {in_y[0], 1'b0};
      end else begin : g_rest
         assign pair = in_y[INDEX -: 2];
      end
   endgenerate

   assign addend = {{(AW-XW){in_x[XW-1]}}, in_x} << INDEX;

   always_comb begin
      case (pair)
         BOOTH_ADD: acc_in = in_acc + addend;
         BOOTH_SUB: acc_in = in_acc - addend;
         default:   acc_in = in_acc;
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         x_ff   <= in_x;
         y_ff   <= in_y;
         acc_ff <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_acc   = acc_ff;

endmodule

### sv/booth_sign_magnitude_fraction_multiply.sv
// Sign-magnitude fraction multiplier, radix-2 Booth in complement form.
// Request channel (req_valid / req_stall) carries two sign-magnitude
// fractions of WIDTH magnitude bits; response channel (rsp_valid /
// rsp_stall) returns the sign-magnitude product with 2*WIDTH fraction bits.
// One response per request transaction, in order. A zero product, negative
// zero operands included, comes back with sign 0.
// The two's complement conversion is registered in the input stage, then
// come the Booth cells (WIDTH+1 cells, each one add/subtract of the shifted
// multiplicand) and the conversion back in the response register.
// Throughput is one transaction per cycle while rsp_stall is low; each stage
// holds one item and moves it on when the next stage is free; bubbles fill.
// When the receiver stalls, the response register holds its payload and the
// stages behind it keep filling; req_stall rises only once all are full.
// Synchronous reset empties every stage; no response is pending after it.
module booth_sign_magnitude_fraction_multiply
   import bsmf_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_multiplicand_sign,
   input  logic [WIDTH-1:0]     req_multiplicand_magnitude,
   input  logic                 req_multiplier_sign,
   input  logic [WIDTH-1:0]     req_multiplier_magnitude,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_product_sign,
   output logic [2*WIDTH-1:0]   rsp_product_magnitude
);

   localparam int AW = 2*WIDTH+2;
   localparam int XW = WIDTH+2;
   localparam int YW = WIDTH+1;
   localparam int NC = WIDTH+1;

   logic            s0_valid_ff;
   logic [XW-1:0]   s0_x_ff;
   logic [YW-1:0]   s0_y_ff;
   logic [XW-1:0]   x_in;
   logic [YW-1:0]   y_in;
   logic            s0_ready;

   logic            c_valid [NC+1];
   logic            c_ready [NC+1];
   logic [XW-1:0]   c_x     [NC+1];
   logic [YW-1:0]   c_y     [NC+1];
   logic [AW-1:0]   c_acc   [NC+1];

   logic                rsp_valid_ff;
   logic                rsp_sign_ff;
   logic [2*WIDTH-1:0]  rsp_mag_ff;
   logic                rsp_ready;
   logic [AW-1:0]       acc_abs;
   logic                acc_nonzero;

   // zero magnitude stays zero whatever its sign
   always_comb begin
      if (req_multiplicand_sign && (req_multiplicand_magnitude != '0)) begin
         x_in = -{2'b00, req_multiplicand_magnitude};
      end else begin
         x_in = {2'b00, req_multiplicand_magnitude};
      end
      if (req_multiplier_sign && (req_multiplier_magnitude != '0)) begin
         y_in = -{1'b0, req_multiplier_magnitude};
      end else begin
         y_in = {1'b0, req_multiplier_magnitude};
      end
   end

   assign s0_ready  = !s0_valid_ff || c_ready[0];
   assign req_stall = !s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s0_ready) begin
         s0_x_ff <= x_in;
         s0_y_ff <= y_in;
      end
   end

   assign c_valid[0] = s0_valid_ff;
   assign c_x[0]     = s0_x_ff;
   assign c_y[0]     = s0_y_ff;
   assign c_acc[0]   = '0;

   generate
      for (genvar i = 0; i < NC; i++) begin : g_cell
         bsmf_cell #(
            .WIDTH (WIDTH),
            .INDEX (i)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .in_x      (c_x[i]),
            .in_y      (c_y[i]),
            .in_acc    (c_acc[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .out_x     (c_x[i+1]),
            .out_y     (c_y[i+1]),
            .out_acc   (c_acc[i+1])
         );
      end
   endgenerate

   assign rsp_ready   = !rsp_valid_ff || !rsp_stall;
   assign c_ready[NC] = rsp_ready;

   assign acc_abs     = c_acc[NC][AW-1] ? -c_acc[NC] : c_acc[NC];
   assign acc_nonzero = (c_acc[NC] != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= c_valid[NC];
      end
   end

   always_ff @(posedge clock) begin
      if (c_valid[NC] && rsp_ready) begin
         rsp_sign_ff <= acc_nonzero && (c_x[NC][XW-1] ^ c_y[NC][YW-1]);
         rsp_mag_ff  <= acc_abs[2*WIDTH-1:0];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_product_sign      = rsp_sign_ff;
   assign rsp_product_magnitude = rsp_mag_ff;

endmodule

### sv/bsmf_checker.sv
`include "booth_sign_magnitude_fraction_multiply_defines.svh"

module bsmf_checker #(
   parameter int WIDTH = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_multiplicand_sign,
   input logic [WIDTH-1:0]     req_multiplicand_magnitude,
   input logic                 req_multiplier_sign,
   input logic [WIDTH-1:0]     req_multiplier_magnitude,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_product_sign,
   input logic [2*WIDTH-1:0]   rsp_product_magnitude
);

   `BSMF_ASSERT(a_rsp_hold, clock, reset,
                rsp_valid && rsp_stall |=> rsp_valid,
                "response dropped while stalled")
   `BSMF_ASSERT(a_rsp_stable, clock, reset,
                rsp_valid && rsp_stall |=>
                   $stable(rsp_product_sign) && $stable(rsp_product_magnitude),
                "stalled response changed")
   `BSMF_ASSERT(a_zero_positive, clock, reset,
                rsp_valid && (rsp_product_magnitude == '0) |-> !rsp_product_sign,
                "zero product reported negative")
   `BSMF_ASSERT(a_no_backpressure, clock, reset,
                !rsp_valid || !rsp_stall |-> !req_stall,
                "request stalled with response side free")
   `BSMF_ASSERT_ALWAYS(a_reset_empty, clock,
                       $past(reset) |-> !rsp_valid,
                       "response pending after reset")

endmodule

bind booth_sign_magnitude_fraction_multiply bsmf_checker #(.WIDTH(WIDTH)) u_bsmf_checker (.*);

### tb/bsmf_product_checker.sv
`timescale 1ns / 100ps

module bsmf_product_checker #(
   parameter int WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_multiplicand_sign,
   input  logic [WIDTH-1:0]   req_multiplicand_magnitude,
   input  logic               req_multiplier_sign,
   input  logic [WIDTH-1:0]   req_multiplier_magnitude,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_product_sign,
   input  logic [2*WIDTH-1:0] rsp_product_magnitude,
   output int                 mismatches,
   output int                 pending
);

   typedef struct packed {
      logic               sign;
      logic [2*WIDTH-1:0] magnitude;
   } product_type;

   product_type expected_products[$];
   int          mismatch_count = 0;
   int          pending_count = 0;

   assign mismatches = mismatch_count;
   assign pending    = pending_count;

   // exact product of two sign-magnitude fractions; zero is always positive
   function automatic product_type fraction_product(input logic xs, input logic [WIDTH-1:0] xm,
                                                    input logic ys, input logic [WIDTH-1:0] ym);
      product_type p;
      p.magnitude = {{WIDTH{1'b0}}, xm} * {{WIDTH{1'b0}}, ym};
      p.sign = (p.magnitude != '0) ? (xs ^ ys) : 1'b0;
      return p;
   endfunction

   always @(posedge clock) begin
      product_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_products.size() == 0) begin
               $error("unexpected transaction: product_sign %0d product_magnitude %0h",
                      rsp_product_sign, rsp_product_magnitude);
               mismatch_count++;
            end else begin
               want = expected_products.pop_front();
               if (rsp_product_sign !== want.sign) begin
                  $error("product_sign: expected %0d, actual %0d", want.sign, rsp_product_sign);
                  mismatch_count++;
               end
               if (rsp_product_magnitude !== want.magnitude) begin
                  $error("product_magnitude: expected %0h, actual %0h",
                         want.magnitude, rsp_product_magnitude);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_products.push_back(fraction_product(req_multiplicand_sign,
                                                         req_multiplicand_magnitude,
                                                         req_multiplier_sign,
                                                         req_multiplier_magnitude));
      end
      pending_count = expected_products.size();
   end

endmodule

### tb/tb_booth_sign_magnitude_fraction_multiply.sv
`timescale 1ns / 100ps

module tb_booth_sign_magnitude_fraction_multiply;

   localparam int WIDTH       = 16;
   localparam int LATENCY     = WIDTH + 3;
   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [WIDTH-1:0] MAG_MAX = '1;
   localparam logic [WIDTH-1:0] MAG_TOP = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [WIDTH-1:0] MAG_LOW = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic [WIDTH-1:0] MAG_ONE = {{(WIDTH-1){1'b0}}, 1'b1};
   localparam logic [WIDTH-1:0] MAG_ALT = {(WIDTH/2){2'b01}};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_multiplicand_sign = 1'b0;
   logic [WIDTH-1:0]   req_multiplicand_magnitude = '0;
   logic               req_multiplier_sign = 1'b0;
   logic [WIDTH-1:0]   req_multiplier_magnitude = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_product_sign;
   logic [2*WIDTH-1:0] rsp_product_magnitude;
   int                 mismatches;
   int                 pending;
   int                 cycles = 0;

   booth_sign_magnitude_fraction_multiply #(.WIDTH(WIDTH)) dut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_multiplicand_sign      (req_multiplicand_sign),
      .req_multiplicand_magnitude (req_multiplicand_magnitude),
      .req_multiplier_sign        (req_multiplier_sign),
      .req_multiplier_magnitude   (req_multiplier_magnitude),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_product_sign           (rsp_product_sign),
      .rsp_product_magnitude      (rsp_product_magnitude)
   );

   bsmf_product_checker #(.WIDTH(WIDTH)) u_product_checker (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_multiplicand_sign      (req_multiplicand_sign),
      .req_multiplicand_magnitude (req_multiplicand_magnitude),
      .req_multiplier_sign        (req_multiplier_sign),
      .req_multiplier_magnitude   (req_multiplier_magnitude),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_product_sign           (rsp_product_sign),
      .rsp_product_magnitude      (rsp_product_magnitude),
      .mismatches                 (mismatches),
      .pending                    (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_operands(input logic xs, input logic [WIDTH-1:0] xm,
                                input logic ys, input logic [WIDTH-1:0] ym);
      req_valid                  <= 1'b1;
      req_multiplicand_sign      <= xs;
      req_multiplicand_magnitude <= xm;
      req_multiplier_sign        <= ys;
      req_multiplier_magnitude   <= ym;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [WIDTH-1:0] pick_magnitude();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return MAG_ONE;
         2:       return MAG_MAX;
         3:       return MAG_TOP;
         4:       return MAG_LOW;
         default: return WIDTH'($urandom);
      endcase
   endfunction

   // receiver: short warm-up, one long hold-off to back up the pipeline, then mixed patterns
   initial begin
      int span;
      int mode;
      @(negedge reset);
      repeat (120) begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
      @(negedge clock);
      rsp_stall <= 1'b1;
      repeat (6 * LATENCY) @(negedge clock);
      forever begin
         span = $urandom_range(5, 60);
         mode = $urandom_range(0, 3);
         repeat (span) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin
      int burst;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_operands(1'b0, '0, 1'b0, '0);
      send_operands(1'b1, '0, 1'b0, MAG_MAX);   // negative zero times nonzero
      send_operands(1'b0, MAG_MAX, 1'b1, '0);
      send_operands(1'b1, '0, 1'b1, '0);
      send_operands(1'b1, MAG_MAX, 1'b0, '0);   // zero product from a negative operand
      send_operands(1'b0, MAG_MAX, 1'b0, MAG_MAX);
      send_operands(1'b1, MAG_MAX, 1'b0, MAG_MAX);
      send_operands(1'b0, MAG_MAX, 1'b1, MAG_MAX);
      send_operands(1'b1, MAG_MAX, 1'b1, MAG_MAX);
      send_operands(1'b0, MAG_ONE, 1'b0, MAG_ONE);
      send_operands(1'b1, MAG_ONE, 1'b0, MAG_MAX);
      send_operands(1'b0, MAG_TOP, 1'b1, MAG_TOP);
      send_operands(1'b1, MAG_LOW, 1'b1, MAG_TOP);
      send_operands(1'b0, MAG_LOW, 1'b0, MAG_LOW);
      send_operands(1'b1, MAG_ALT, 1'b0, ~MAG_ALT);
      send_operands(1'b0, ~MAG_ALT, 1'b1, ~MAG_ALT);
      send_operands(1'b1, MAG_ALT, 1'b1, MAG_ALT);
      send_operands(1'b0, MAG_ONE, 1'b1, MAG_TOP);
      send_operands(1'b1, MAG_MAX, 1'b1, MAG_ONE);

      burst = $urandom_range(1, 30);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            burst = $urandom_range(1, 30);
         end
         send_operands(1'($urandom), pick_magnitude(), 1'($urandom), pick_magnitude());
         burst--;
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (4 * LATENCY) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/bsmf_pkg.sv
sv/bsmf_cell.sv
sv/booth_sign_magnitude_fraction_multiply.sv
sv/bsmf_checker.sv
tb/bsmf_product_checker.sv
tb/tb_booth_sign_magnitude_fraction_multiply.sv
